// File: hdl/signed_add_mul_div_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed add / multiply / divide unit
// Shared helpers that wrap concurrent assertions clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_ADD_MUL_DIV_UNIT_DEFINES_SVH
`define SIGNED_ADD_MUL_DIV_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SAMDU_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define SAMDU_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hdl/samdu_pkg.sv
// ----------------------------------------------------------------------------
// samdu_pkg
// Types and constants shared by the signed add / multiply / divide unit.
// ----------------------------------------------------------------------------
package samdu_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int PORT_OPERAND_W    = 32;
    localparam int CMD_W             = 2;
    localparam int MAIN_W            = 64;
    localparam int REM_W             = 33;
    localparam int S_TDATA_W         = 2 * PORT_OPERAND_W;
    localparam int M_TDATA_W         = ((MAIN_W + REM_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 2'd0,
        CMD_MUL = 2'd1,
        CMD_DIV = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_NEG_A,
        ST_NEG_B,
        ST_DIV,
        ST_FIX_R,
        ST_FIX_Q,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic   load;
        logic   last;
        t_state phase;
    } t_dp_ctl;

    typedef struct packed {
        logic div_zero;
    } t_dp_stat;

endpackage

// File: hdl/signed_add_mul_div_unit.sv
// ----------------------------------------------------------------------------
// signed_add_mul_div_unit
// Signed add, shift-and-add multiply and shift-and-subtract divide.
// ----------------------------------------------------------------------------
// The input stream carries one command word: operand a in s_axis_tdata[31:0],
// operand b in s_axis_tdata[63:32], the operation in s_axis_tuser. Only the
// low OPERAND_WIDTH bits of each operand are used, sign-extended.
// The output stream returns one word per command: the sum, product or
// quotient, the remainder and the divide-by-zero flag.
// All work runs through a single adder of OPERAND_WIDTH+1 bits under a
// small sequencer, and a new word is taken only when the sequencer is idle.
// A divide by zero ends after the first magnitude step, and an unused
// command goes straight to the result without any adder step.
// Multiply uses one adder step per multiplier bit; divide adds two steps to
// take magnitudes and two to apply the signs to quotient and remainder.
// The result sits in an output register, so the next word is accepted while
// the receiver stalls; the sequencer only waits when a second result is done
// and the first has not been taken. Reset clears the sequencer and the
// output valid; no word is in flight afterwards.
// ----------------------------------------------------------------------------
`include "signed_add_mul_div_unit_defines.svh"

module signed_add_mul_div_unit #(
    parameter int OPERAND_WIDTH = samdu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] operand_a, [63:32] operand_b
    input  logic [samdu_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] cmd
    input  logic [samdu_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [63:0] main_result, [96:64] remainder, [103:97] zero
    output logic [samdu_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] divide_by_zero
    output logic                               m_axis_tuser
);

    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    samdu_pkg::t_state   r_state;
    samdu_pkg::t_state   n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic                r_out_valid;
    logic [samdu_pkg::MAIN_W-1:0] r_out_main;
    logic [samdu_pkg::REM_W-1:0]  r_out_rem;
    logic                r_out_dz;

    samdu_pkg::t_dp_ctl  w_ctl;
    samdu_pkg::t_dp_stat w_stat;
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_out_load;
    logic [samdu_pkg::MAIN_W-1:0] w_main;
    logic [samdu_pkg::REM_W-1:0]  w_rem;
    logic                w_dz;

    assign s_axis_tready = (r_state == samdu_pkg::ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    samdu_datapath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_cmd  (s_axis_tuser),
        .i_a    (s_axis_tdata[samdu_pkg::PORT_OPERAND_W-1:0]),
        .i_b    (s_axis_tdata[samdu_pkg::S_TDATA_W-1:samdu_pkg::PORT_OPERAND_W]),
        .o_stat (w_stat),
        .o_main (w_main),
        .o_rem  (w_rem),
        .o_dz   (w_dz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= samdu_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        w_out_load  = 1'b0;
        w_ctl.load  = 1'b0;
        w_ctl.phase = r_state;
        w_ctl.last  = (r_cnt == CNT_W'(OPERAND_WIDTH - 1));
        case (r_state)
            samdu_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (w_in_acc) begin
                    w_ctl.load = 1'b1;
                    case (s_axis_tuser)
                        samdu_pkg::CMD_ADD: n_state = samdu_pkg::ST_ADD;
                        samdu_pkg::CMD_MUL: n_state = samdu_pkg::ST_MUL;
                        samdu_pkg::CMD_DIV: n_state = samdu_pkg::ST_NEG_A;
                        default:            n_state = samdu_pkg::ST_DONE;
                    endcase
                end
            end
            samdu_pkg::ST_ADD: begin
                n_state = samdu_pkg::ST_DONE;
            end
            samdu_pkg::ST_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (w_ctl.last) begin
                    n_state = samdu_pkg::ST_DONE;
                end
            end
            samdu_pkg::ST_NEG_A: begin
                n_state = w_stat.div_zero ? samdu_pkg::ST_DONE : samdu_pkg::ST_NEG_B;
            end
            samdu_pkg::ST_NEG_B: begin
                n_cnt   = '0;
                n_state = samdu_pkg::ST_DIV;
            end
            samdu_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (w_ctl.last) begin
                    n_state = samdu_pkg::ST_FIX_R;
                end
            end
            samdu_pkg::ST_FIX_R: begin
                n_state = samdu_pkg::ST_FIX_Q;
            end
            samdu_pkg::ST_FIX_Q: begin
                n_state = samdu_pkg::ST_DONE;
            end
            samdu_pkg::ST_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = samdu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = samdu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_main <= w_main;
            r_out_rem  <= w_rem;
            r_out_dz   <= w_dz;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(samdu_pkg::M_TDATA_W - samdu_pkg::MAIN_W - samdu_pkg::REM_W)'(0),
                            r_out_rem, r_out_main};
    assign m_axis_tuser  = r_out_dz;

    `SAMDU_ASSERT_NEXT(a_busy_after_accept, w_in_acc, r_state != samdu_pkg::ST_IDLE,
        "sequencer idle after accepting a word")
    `SAMDU_ASSERT_NOW(a_step_count_range,
        (r_state == samdu_pkg::ST_MUL) || (r_state == samdu_pkg::ST_DIV),
        r_cnt <= CNT_W'(OPERAND_WIDTH - 1), "step counter past the last operand bit")
    `SAMDU_ASSERT_NOW(a_div_zero_result, m_axis_tvalid && m_axis_tuser, r_out_main == '1,
        "divide by zero without all-ones quotient")
    `SAMDU_ASSERT_NOW(a_no_overwrite, r_out_valid && !m_axis_tready, !w_out_load,
        "result register loaded while a stalled word waits")

endmodule

// File: hdl/samdu_datapath.sv
// ----------------------------------------------------------------------------
// samdu_datapath
// Operand and accumulator registers around one shared add/subtract unit.
// ----------------------------------------------------------------------------
module samdu_datapath #(
    parameter int OPERAND_WIDTH = samdu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  samdu_pkg::t_dp_ctl                  i_ctl,
    input  logic [samdu_pkg::CMD_W-1:0]          i_cmd,
    input  logic [samdu_pkg::PORT_OPERAND_W-1:0] i_a,
    input  logic [samdu_pkg::PORT_OPERAND_W-1:0] i_b,
    output samdu_pkg::t_dp_stat                 o_stat,
    output logic [samdu_pkg::MAIN_W-1:0]         o_main,
    output logic [samdu_pkg::REM_W-1:0]          o_rem,
    output logic                                o_dz
);

    localparam int W = OPERAND_WIDTH;

    logic [samdu_pkg::CMD_W-1:0] r_cmd;
    logic [W-1:0]                r_a;
    logic [W-1:0]                r_b;
    logic [W:0]                  r_hi;
    logic [W-1:0]                r_lo;
    logic                        r_dz;
    logic                        r_neg_q;
    logic                        r_neg_r;

    logic signed [W-1:0]   w_a_s;
    logic signed [W-1:0]   w_b_s;
    logic [W:0]            w_x;
    logic [W:0]            w_y;
    logic                  w_sub;
    logic [W:0]            w_s;
    logic signed [W:0]     w_hi_s;
    logic signed [2*W-1:0] w_prod_s;
    logic signed [W-1:0]   w_rem_s;

    assign w_a_s = r_a;
    assign w_b_s = r_b;

    // Operand selection for the shared adder, chosen by the current phase.
    always_comb begin
        w_x   = '0;
        w_y   = '0;
        w_sub = 1'b0;
        case (i_ctl.phase)
            samdu_pkg::ST_ADD: begin
                w_x = (W+1)'(w_a_s);
                w_y = (W+1)'(w_b_s);
            end
            samdu_pkg::ST_MUL: begin
                // The sign bit of the multiplier carries negative weight.
                w_x   = r_hi;
                w_y   = r_lo[0] ? (W+1)'(w_a_s) : '0;
                w_sub = i_ctl.last;
            end
            samdu_pkg::ST_NEG_A: begin
                w_y   = (W+1)'(w_a_s);
                w_sub = 1'b1;
            end
            samdu_pkg::ST_NEG_B: begin
                w_y   = (W+1)'(w_b_s);
                w_sub = 1'b1;
            end
            samdu_pkg::ST_DIV: begin
                w_x   = {r_hi[W-1:0], r_lo[W-1]};
                w_y   = {1'b0, r_b};
                w_sub = 1'b1;
            end
            samdu_pkg::ST_FIX_R: begin
                w_y   = r_hi;
                w_sub = 1'b1;
            end
            samdu_pkg::ST_FIX_Q: begin
                w_y   = {1'b0, r_lo};
                w_sub = 1'b1;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_s = w_x + (w_sub ? ~w_y : w_y) + (W+1)'(w_sub);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_a   <= i_a[W-1:0];
            r_b   <= i_b[W-1:0];
            r_hi  <= '0;
            r_lo  <= i_b[W-1:0];
            r_dz  <= (i_b[W-1:0] == '0);
        end else begin
            case (i_ctl.phase)
                samdu_pkg::ST_ADD: begin
                    r_hi <= w_s;
                end
                samdu_pkg::ST_MUL: begin
                    r_hi <= {w_s[W], w_s[W:1]};
                    r_lo <= {w_s[0], r_lo[W-1:1]};
                end
                samdu_pkg::ST_NEG_A: begin
                    r_lo    <= r_a[W-1] ? w_s[W-1:0] : r_a;
                    r_neg_r <= r_a[W-1];
                    r_neg_q <= r_a[W-1] ^ r_b[W-1];
                end
                samdu_pkg::ST_NEG_B: begin
                    r_b <= r_b[W-1] ? w_s[W-1:0] : r_b;
                end
                samdu_pkg::ST_DIV: begin
                    // Restore the partial remainder when the trial subtract goes negative.
                    r_hi <= w_s[W] ? w_x : w_s;
                    r_lo <= {r_lo[W-2:0], ~w_s[W]};
                end
                samdu_pkg::ST_FIX_R: begin
                    r_b <= r_neg_r ? w_s[W-1:0] : r_hi[W-1:0];
                end
                samdu_pkg::ST_FIX_Q: begin
                    r_hi <= r_neg_q ? w_s : {1'b0, r_lo};
                end
                default: begin
                    r_hi <= r_hi;
                end
            endcase
        end
    end

    assign w_hi_s   = r_hi;
    assign w_prod_s = {r_hi[W-1:0], r_lo};
    assign w_rem_s  = r_b;

    always_comb begin
        o_main = '0;
        o_rem  = '0;
        o_dz   = 1'b0;
        case (r_cmd)
            samdu_pkg::CMD_ADD: begin
                o_main = samdu_pkg::MAIN_W'(w_hi_s);
            end
            samdu_pkg::CMD_MUL: begin
                o_main = samdu_pkg::MAIN_W'(w_prod_s);
            end
            samdu_pkg::CMD_DIV: begin
                if (r_dz) begin
                    o_main = '1;
                    o_rem  = samdu_pkg::REM_W'(w_a_s);
                    o_dz   = 1'b1;
                end else begin
                    o_main = samdu_pkg::MAIN_W'(w_hi_s);
                    o_rem  = samdu_pkg::REM_W'(w_rem_s);
                end
            end
            default: begin
                o_dz = 1'b0;
            end
        endcase
    end

    assign o_stat.div_zero = r_dz;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signed add / multiply / divide unit. Command
// words go in on the slave stream, and an in-bench model of the arithmetic
// predicts each result word. Results are compared field by field in order.
// The run has directed corner words, random words under several idle and
// stall mixes, and one long receiver hold-off that fills the unit.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [samdu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [31:0] OP_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] OP_MIN  = 32'h8000_0000;
    localparam logic [31:0] OP_NEG1 = 32'hFFFF_FFFF;

    localparam int RANDOM_WORDS_PER_PHASE = 420;
    localparam int HOLD_CYCLES            = 300;
    localparam int DRAIN_CYCLES           = 60;

    typedef struct packed {
        logic [samdu_pkg::MAIN_W-1:0] main_result;
        logic [samdu_pkg::REM_W-1:0]  remainder;
        logic                         div_by_zero;
    } t_alu_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // [31:0] operand_a, [63:32] operand_b
    logic [samdu_pkg::S_TDATA_W-1:0] s_axis_tdata;
    // [1:0] cmd
    logic [samdu_pkg::CMD_W-1:0]     s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // [63:0] main_result, [96:64] remainder, [103:97] zero
    logic [samdu_pkg::M_TDATA_W-1:0] m_axis_tdata;
    // [0] divide_by_zero
    logic                            m_axis_tuser;

    t_alu_result alu_result_q[$];
    int          mismatch_count = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    signed_add_mul_div_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Exact arithmetic on the sign-extended operands. Division takes the
    // magnitudes, so the most negative dividend needs more than 32-bit signed math.
    function automatic t_alu_result predict_alu(input logic [samdu_pkg::CMD_W-1:0] op,
                                                input logic [31:0] a,
                                                input logic [31:0] b);
        t_alu_result r;
        logic [63:0] sa, sb, ma, mb, quot, diff;
        r  = '0;
        sa = {{32{a[31]}}, a};
        sb = {{32{b[31]}}, b};
        case (op)
            samdu_pkg::CMD_ADD: begin
                r.main_result = sa + sb;
            end
            samdu_pkg::CMD_MUL: begin
                r.main_result = sa * sb;
            end
            samdu_pkg::CMD_DIV: begin
                if (sb == 64'd0) begin
                    r.div_by_zero = 1'b1;
                    r.main_result = '1;
                    diff          = sa + sb;
                    r.remainder   = diff[samdu_pkg::REM_W-1:0];
                end else begin
                    ma   = sa[63] ? 64'd0 - sa : sa;
                    mb   = sb[63] ? 64'd0 - sb : sb;
                    quot = ma / mb;
                    if (sa[63] != sb[63]) quot = 64'd0 - quot;
                    diff          = sa - quot * sb;
                    r.main_result = quot;
                    r.remainder   = diff[samdu_pkg::REM_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0:       v = 32'd0;
                    1:       v = 32'd1;
                    2:       v = OP_NEG1;
                    3:       v = OP_MAX;
                    default: v = OP_MIN;
                endcase
            end
            1, 2: begin
                v = $urandom_range(255);
                if ($urandom_range(1)) v = 32'd0 - v;
            end
            3: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1)) v = 32'd0 - v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_word(input logic [samdu_pkg::CMD_W-1:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        alu_result_q.push_back(predict_alu(op, a, b));
    endtask

    task automatic send_random_word();
        logic [samdu_pkg::CMD_W-1:0] op;
        logic [31:0]                 a, b;
        int                          sel;
        sel = $urandom_range(15);
        if (sel == 0)      op = CMD_UNUSED;
        else if (sel < 6)  op = samdu_pkg::CMD_ADD;
        else if (sel < 11) op = samdu_pkg::CMD_MUL;
        else               op = samdu_pkg::CMD_DIV;
        a = pick_operand();
        b = pick_operand();
        if (op == samdu_pkg::CMD_DIV && $urandom_range(15) == 0) b = 32'd0;
        send_word(op, a, b);
    endtask

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_seq;
        end
        if (hold_left > 0) begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (alu_result_q.size() == 0) begin
                $display("%0t: unexpected word, main_result %h remainder %h flag %b",
                         $time, m_axis_tdata[63:0], m_axis_tdata[96:64], m_axis_tuser);
                mismatch_count++;
            end else begin
                want = alu_result_q.pop_front();
                if (m_axis_tdata[63:0] !== want.main_result) begin
                    $display("%0t: main_result expected %h actual %h",
                             $time, want.main_result, m_axis_tdata[63:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[96:64] !== want.remainder) begin
                    $display("%0t: remainder expected %h actual %h",
                             $time, want.remainder, m_axis_tdata[96:64]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.div_by_zero) begin
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, want.div_by_zero, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_add_extremes();
        send_word(samdu_pkg::CMD_ADD, OP_MAX, OP_MAX);
        send_word(samdu_pkg::CMD_ADD, OP_MIN, OP_MIN);
        send_word(samdu_pkg::CMD_ADD, OP_MIN, OP_NEG1);
        send_word(samdu_pkg::CMD_ADD, OP_MAX, 32'd1);
        send_word(samdu_pkg::CMD_ADD, 32'd0, 32'd0);
    endtask

    task automatic test_mul_extremes();
        send_word(samdu_pkg::CMD_MUL, OP_MAX, OP_MAX);
        send_word(samdu_pkg::CMD_MUL, OP_MIN, OP_MIN);
        send_word(samdu_pkg::CMD_MUL, OP_MIN, OP_MAX);
        send_word(samdu_pkg::CMD_MUL, OP_NEG1, OP_MIN);
        send_word(samdu_pkg::CMD_MUL, 32'd0, OP_MIN);
        send_word(samdu_pkg::CMD_MUL, 32'hDEAD_BEEF, 32'h1234_5678);
    endtask

    // Sign combinations, the most negative dividend, and zero divisors.
    task automatic test_div_cases();
        send_word(samdu_pkg::CMD_DIV, 32'd7, 32'd2);
        send_word(samdu_pkg::CMD_DIV, 32'd0 - 32'd7, 32'd2);
        send_word(samdu_pkg::CMD_DIV, 32'd7, 32'd0 - 32'd2);
        send_word(samdu_pkg::CMD_DIV, 32'd0 - 32'd7, 32'd0 - 32'd2);
        send_word(samdu_pkg::CMD_DIV, OP_MIN, OP_NEG1);
        send_word(samdu_pkg::CMD_DIV, OP_MIN, 32'd1);
        send_word(samdu_pkg::CMD_DIV, OP_MAX, OP_MIN);
        send_word(samdu_pkg::CMD_DIV, OP_MIN, OP_MIN);
        send_word(samdu_pkg::CMD_DIV, 32'd5, 32'd0);
        send_word(samdu_pkg::CMD_DIV, OP_MIN, 32'd0);
        send_word(samdu_pkg::CMD_DIV, 32'd0, 32'd0);
        send_word(samdu_pkg::CMD_DIV, 32'd3, OP_MAX);
    endtask

    task automatic test_unused_cmd();
        send_word(CMD_UNUSED, OP_MAX, OP_MIN);
        send_word(CMD_UNUSED, OP_NEG1, OP_NEG1);
    endtask

    task automatic test_random_phase(input int count, input int src_pct,
                                     input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (count) send_random_word();
    endtask

    // The receiver holds off while the sender keeps offering words, so the
    // output register and the sequencer fill and the input stalls.
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_seq      = hold_seq + 1;
        repeat (24) send_random_word();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_add_extremes();
        test_mul_extremes();
        test_div_cases();
        test_unused_cmd();
        test_random_phase(RANDOM_WORDS_PER_PHASE, 0, 0);
        test_random_phase(RANDOM_WORDS_PER_PHASE, 76, 0);
        test_random_phase(RANDOM_WORDS_PER_PHASE, 0, 76);
        test_random_phase(RANDOM_WORDS_PER_PHASE, 38, 38);
        test_output_backpressure();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (alu_result_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
